// ----- sv/rthsv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Widths, hue constants, the pipeline side-band record and the one-bit
// restoring division step shared by the divider stages.
// ----------------------------------------------------------------------------
package rthsv_pkg;

	localparam int CB         = 10;                 // bits per color component
	localparam int HUE_W      = 15;                 // hue in 1/64 degree
	localparam int SAT_W      = 8;
	localparam int HQ_W       = 12;                 // hue quotient bits (max 3840)
	localparam int SQ_W       = 8;                  // saturation quotient bits
	localparam int DIV_STEPS  = 2;                  // quotient bits per stage
	localparam int DIV_STAGES = HQ_W / DIV_STEPS;
	localparam int HACC_W     = CB + HQ_W;
	localparam int SACC_W     = CB + SQ_W;
	localparam int IN_W       = ((3 * CB + 7) / 8) * 8;
	localparam int OUT_W      = ((HUE_W + SAT_W + CB + 7) / 8) * 8;

	// 60 degrees in 1/64 degree, and the sector offsets.
	localparam logic [HQ_W-1:0]  HUE_SCALE  = 12'd3840;
	localparam logic [HUE_W-1:0] HUE_RED    = 15'd0;
	localparam logic [HUE_W-1:0] HUE_GREEN  = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_BLUE   = 15'd15360;
	localparam logic [HUE_W-1:0] HUE_WRAP   = 15'd23040;
	localparam logic [SAT_W-1:0] SAT_SCALE  = 8'd255;

	typedef struct packed {
		logic [CB-1:0]    d;     // max - min
		logic [CB-1:0]    mx;    // largest component
		logic [HUE_W-1:0] base;  // sector offset
		logic             neg;   // hue numerator is negative
	} side_t;

	// One step of restoring division: remainder is below the divisor on entry.
	// Returns the quotient bit on top of the new remainder.
	function automatic logic [CB:0] div_step(input logic [CB-1:0] rem, input logic nb,
	                                         input logic [CB-1:0] dv);
		logic [CB:0] t;
		logic [CB:0] diff;
		t    = {rem, nb};
		diff = t - {1'b0, dv};
		if (t >= {1'b0, dv}) begin
			return {1'b1, diff[CB-1:0]};
		end
		return {1'b0, t[CB-1:0]};
	endfunction

endpackage
`default_nettype wire

// ----- sv/rgb_to_hsv_converter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Streaming pixel converter: hue in 1/64 degree, 8-bit saturation, value.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock while not stalled and returns one
// HSV beat per pixel, in order. The pipeline holds two restoring dividers
// (hue quotient of 12 bits and saturation quotient of 8 bits), which resolve
// two quotient bits per pipeline stage over six stages, plus a min/max stage,
// a scaling stage and the output register. The whole pipeline holds while the
// output beat is not taken, so s_axis_tready follows m_axis_tready whenever the
// output register is full. A gray pixel gives hue 0 and saturation 0.
module rgb_to_hsv_converter_top (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	// red, green, blue (low bits up), zero padding on top
	input  wire logic [rthsv_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	// hue, saturation, brightness (low bits up), zero padding on top
	output logic [rthsv_pkg::OUT_W-1:0]   m_axis_tdata
);
	import rthsv_pkg::*;

	logic ce;

	// Stage 1: max/min, sector selection and hue numerator magnitude.
	logic [CB-1:0] red, green, blue;
	logic [CB-1:0] mx, mn, opa, opb;
	logic [HUE_W-1:0] base;
	side_t side_c;
	logic [CB-1:0] mag_c;

	side_t         side_s1;
	logic [CB-1:0] mag_s1;
	logic          vld_s1;

	// Stage 2: scaled numerators loaded into the divider accumulators.
	side_t             side_s2;
	logic [HACC_W-1:0] hacc_s2;
	logic [SACC_W-1:0] sacc_s2;
	logic              vld_s2;

	// Divider stages.
	side_t             side_sd [0:DIV_STAGES-1];
	logic [HACC_W-1:0] hacc_sd [0:DIV_STAGES-1];
	logic [SACC_W-1:0] sacc_sd [0:DIV_STAGES-1];
	logic              vld_sd  [0:DIV_STAGES-1];

	// Output register.
	logic [HUE_W-1:0] hue_q;
	logic [SAT_W-1:0] sat_q;
	logic [CB-1:0]    bright_q;
	logic             vld_q;

	assign ce            = !vld_q || m_axis_tready;
	assign s_axis_tready = ce;
	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = OUT_W'({bright_q, sat_q, hue_q});

	assign red   = s_axis_tdata[CB-1:0];
	assign green = s_axis_tdata[2*CB-1:CB];
	assign blue  = s_axis_tdata[3*CB-1:2*CB];

	always_comb begin
		// Red wins ties with green and blue, green wins ties with blue.
		if (red >= green && red >= blue) begin
			mx   = red;
			opa  = green;
			opb  = blue;
			base = HUE_RED;
		end else if (green >= blue) begin
			mx   = green;
			opa  = blue;
			opb  = red;
			base = HUE_GREEN;
		end else begin
			mx   = blue;
			opa  = red;
			opb  = green;
			base = HUE_BLUE;
		end
		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
		side_c.mx  = mx;
		side_c.d   = mx - mn;
		side_c.neg = opa < opb;
		mag_c      = side_c.neg ? (opb - opa) : (opa - opb);
		// A negative numerator with red largest wraps around by 360 degrees.
		side_c.base = (side_c.neg && base == HUE_RED) ? HUE_WRAP : base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (ce) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_q  <= vld_sd[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			side_s1 <= side_c;
			mag_s1  <= mag_c;
			side_s2 <= side_s1;
			// The top bits of each scaled numerator are already below the divisor.
			hacc_s2 <= HACC_W'(mag_s1) * HACC_W'(HUE_SCALE);
			sacc_s2 <= SACC_W'(side_s1.d) * SACC_W'(SAT_SCALE);
		end
	end

	genvar k;
	generate
		for (k = 0; k < DIV_STAGES; k++) begin : g_div
			side_t             side_in;
			logic [HACC_W-1:0] hacc_in, hacc_nx;
			logic [SACC_W-1:0] sacc_in, sacc_nx;
			logic              vld_in;
			logic [CB:0]       hres, sres;

			if (k == 0) begin : g_first
				assign side_in = side_s2;
				assign hacc_in = hacc_s2;
				assign sacc_in = sacc_s2;
				assign vld_in  = vld_s2;
			end else begin : g_next
				assign side_in = side_sd[k-1];
				assign hacc_in = hacc_sd[k-1];
				assign sacc_in = sacc_sd[k-1];
				assign vld_in  = vld_sd[k-1];
			end

			always_comb begin
				hacc_nx = hacc_in;
				sacc_nx = sacc_in;
				for (int j = 0; j < DIV_STEPS; j++) begin
					hres    = div_step(hacc_nx[HACC_W-1:HQ_W], hacc_nx[HQ_W-1], side_in.d);
					hacc_nx = {hres[CB-1:0], hacc_nx[HQ_W-2:0], hres[CB]};
					sres    = div_step(sacc_nx[SACC_W-1:SQ_W], sacc_nx[SQ_W-1], side_in.mx);
					// The saturation quotient is complete after its first stages.
					if (k * DIV_STEPS + j < SQ_W) begin
						sacc_nx = {sres[CB-1:0], sacc_nx[SQ_W-2:0], sres[CB]};
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_sd[k] <= 1'b0;
				end else if (ce) begin
					vld_sd[k] <= vld_in;
				end
			end

			always_ff @(posedge clk) begin
				if (ce) begin
					side_sd[k] <= side_in;
					hacc_sd[k] <= hacc_nx;
					sacc_sd[k] <= sacc_nx;
				end
			end
		end
	endgenerate

	// Final hue: floor of base plus or minus the quotient.
	side_t            side_l;
	logic [HQ_W-1:0]  hq;
	logic [CB-1:0]    hrem;
	logic [HUE_W-1:0] hue_c;
	logic [SAT_W-1:0] sat_c;

	assign side_l = side_sd[DIV_STAGES-1];
	assign hq     = hacc_sd[DIV_STAGES-1][HQ_W-1:0];
	assign hrem   = hacc_sd[DIV_STAGES-1][HACC_W-1:HQ_W];

	always_comb begin
		if (side_l.neg) begin
			hue_c = side_l.base - HUE_W'(hq) - HUE_W'(hrem != '0);
		end else begin
			hue_c = side_l.base + HUE_W'(hq);
		end
		sat_c = sacc_sd[DIV_STAGES-1][SQ_W-1:0];
		if (side_l.d == '0) begin
			hue_c = '0;
			sat_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			hue_q    <= hue_c;
			sat_q    <= sat_c;
			bright_q <= side_l.mx;
		end
	end

endmodule
`default_nettype wire
